/* hdl/bndc_pkg.sv */
// Shared constants, codes and types of the base-N digit counter.
`default_nettype none

package bndc_pkg;

    // Digit row geometry.
    localparam int MAX_DIGITS  = 8;
    localparam int DIGIT_WIDTH = 8;
    localparam int IDX_W       = $clog2(MAX_DIGITS);

    // Field and register widths.
    localparam int VALUE_W  = 64;
    localparam int BASE_W   = 9;
    localparam int COUNT_W  = 4;
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 4;
    localparam int NEWDIG_W = 8;
    localparam int OUTDIG_W = 8;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Largest usable base is bounded by the digit width.
    localparam int BASE_TOP = ((1 << DIGIT_WIDTH) > 256) ? 256 : (1 << DIGIT_WIDTH);

    // Bit-serial divider produces one quotient bit per cycle.
    localparam int DIV_STEPS = VALUE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = $clog2(BASE_TOP);

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INC   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

    // Configuration register indexes, taken from paddr bit 2.
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_NUM  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [BASE_W-1:0]  BASE_RESET = 9'd10;
    localparam logic [COUNT_W-1:0] NUM_RESET  = 4'd8;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic step;
    } mac_ctl_t;

endpackage

`default_nettype wire

/* hdl/bndc_divider.sv */
// Bit-serial restoring divider: 64-bit dividend by the counting base.
`default_nettype none

module bndc_divider
    import bndc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [VALUE_W-1:0] dividend,
    input  wire logic [BASE_W-1:0]  divisor,
    output logic                    done,
    output logic [VALUE_W-1:0]      quotient,
    output logic [REM_W-1:0]        remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   quo_reg, quo_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [BASE_W-1:0]    trial;
    logic [BASE_W-1:0]    diff;
    logic                 fits;

    // One trial subtraction per cycle; the dividend shifts out as quotient bits shift in.
    assign trial = {rem_reg, quo_reg[VALUE_W-1]};
    assign fits  = (trial >= divisor);
    assign diff  = trial - divisor;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            quo_next = {quo_reg[VALUE_W-2:0], fits};
            rem_next = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* hdl/bndc_mac.sv */
// Shared multiply-accumulate unit: acc = acc * base + addend, one step per cycle.
`default_nettype none

module bndc_mac
    import bndc_pkg::*;
(
    input  wire logic                   clk,
    input  wire mac_ctl_t               ctl,
    input  wire logic [BASE_W-1:0]      base,
    input  wire logic [DIGIT_WIDTH-1:0] addend,
    output logic [VALUE_W-1:0]          acc
);

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] product;

    // Horner step, wrapping modulo 2^64.
    assign product = acc_reg * VALUE_W'(base);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.step)
        begin
            acc_next = product + VALUE_W'(addend);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* hdl/base_n_digit_counter.sv */
// Top level of the base-N digit counter: configuration, sequencer and digit row.
//
// Usage:
// Requests enter on the input channel (in_valid / in_stall) and each produces
// exactly one result on the output channel (out_valid / out_stall). The block
// works on one request at a time and holds in_stall high while busy.
// A request first does its action: a load runs the bit-serial divider once per
// digit, an increment ripples its carry upward and a read fetches the digit;
// clear, write, an unused action or a bad index go straight on to evaluation.
// The binary value and the maximum value are both evaluated in the one shared
// multiply-accumulate unit, one digit a cycle.
// The next request can be taken once the result appears; the block takes no
// new request before it is through with the last one.
// The result sits in an output register, so a stalled receiver only holds the
// finished result; a following request is still taken and computed, and its
// result waits in the sequencer until that register is free.
// Reset clears all digits and sets base 10 and 8 digits.
// Configuration is to be written over the APB port only while the block is idle; the block does not enforce this.
`default_nettype none

module base_n_digit_counter
    import bndc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    // Request channel.
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [INDEX_W-1:0]  digit_index,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic [NEWDIG_W-1:0] new_digit,
    // Result channel.
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     rolled_over,
    output logic [VALUE_W-1:0]       binary_value,
    output logic [OUTDIG_W-1:0]      digit_value,
    output logic [VALUE_W-1:0]       max_value
);

    // Sequencer states.
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE = 3'd0;
    localparam logic [ST_W-1:0] S_DIV  = 3'd1;
    localparam logic [ST_W-1:0] S_INC  = 3'd2;
    localparam logic [ST_W-1:0] S_READ = 3'd3;
    localparam logic [ST_W-1:0] S_SUM  = 3'd4;
    localparam logic [ST_W-1:0] S_MID  = 3'd5;
    localparam logic [ST_W-1:0] S_MAX  = 3'd6;
    localparam logic [ST_W-1:0] S_DONE = 3'd7;

    logic [BASE_W-1:0]      base_reg;
    logic [COUNT_W-1:0]     num_reg;
    logic [BASE_W-1:0]      eff_base;
    logic [COUNT_W-1:0]     eff_num;
    logic [IDX_W-1:0]       last_idx;

    logic [ST_W-1:0]        state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [DIGIT_WIDTH-1:0] digits_reg [MAX_DIGITS];
    logic [DIGIT_WIDTH-1:0] digits_next [MAX_DIGITS];
    logic                   rolled_reg, rolled_next;
    logic [DIGIT_WIDTH-1:0] rd_reg, rd_next;
    logic [VALUE_W-1:0]     sum_reg, sum_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_rolled_reg, out_rolled_next;
    logic [VALUE_W-1:0]     out_bin_reg, out_bin_next;
    logic [OUTDIG_W-1:0]    out_digit_reg, out_digit_next;
    logic [VALUE_W-1:0]     out_max_reg, out_max_next;

    logic                   start_sum;
    logic [DIGIT_WIDTH-1:0] cur_digit;
    logic [BASE_W-1:0]      inc_digit;

    logic                   div_start;
    logic [VALUE_W-1:0]     div_dividend;
    logic                   div_done;
    logic [VALUE_W-1:0]     div_quotient;
    logic [REM_W-1:0]       div_remainder;

    mac_ctl_t               mac_ctl;
    logic [DIGIT_WIDTH-1:0] mac_addend;
    logic [VALUE_W-1:0]     mac_acc;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            num_reg  <= NUM_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_BASE: base_reg <= pwdata[BASE_W-1:0];
                REG_NUM:  num_reg  <= pwdata[COUNT_W-1:0];
                default:  ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM) ? APB_DW'(num_reg) : APB_DW'(base_reg);

    // Clamp the base and digit count into their usable ranges.
    always_comb
    begin
        eff_base = base_reg;
        if (base_reg < BASE_W'(2))
        begin
            eff_base = BASE_W'(2);
        end
        else if (base_reg > BASE_W'(BASE_TOP))
        begin
            eff_base = BASE_W'(BASE_TOP);
        end
        eff_num = num_reg;
        if (num_reg < COUNT_W'(1))
        begin
            eff_num = COUNT_W'(1);
        end
        else if (num_reg > COUNT_W'(MAX_DIGITS))
        begin
            eff_num = COUNT_W'(MAX_DIGITS);
        end
    end

    assign last_idx  = IDX_W'(eff_num - 1'b1);
    assign cur_digit = digits_reg[idx_reg];
    assign inc_digit = BASE_W'(cur_digit) + 1'b1;

    // Shared arithmetic units.
    bndc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_base),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    bndc_mac u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .base   (eff_base),
        .addend (mac_addend),
        .acc    (mac_acc)
    );

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        digits_next     = digits_reg;
        rolled_next     = rolled_reg;
        rd_next         = rd_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg;
        out_rolled_next = out_rolled_reg;
        out_bin_next    = out_bin_reg;
        out_digit_next  = out_digit_reg;
        out_max_next    = out_max_reg;
        start_sum       = 1'b0;
        div_start       = 1'b0;
        div_dividend    = div_quotient;
        mac_ctl         = '0;
        mac_addend      = cur_digit;

        // The receiver takes the pending result.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rolled_next = 1'b0;
                    rd_next     = '0;
                    unique case (action) inside
                        ACT_CLEAR:
                        begin
                            digits_next = '{default: '0};
                            start_sum   = 1'b1;
                        end
                        ACT_LOAD:
                        begin
                            digits_next  = '{default: '0};
                            idx_next     = '0;
                            div_start    = 1'b1;
                            div_dividend = value;
                            state_next   = S_DIV;
                        end
                        ACT_INC, ACT_WRITE, ACT_READ:
                        begin
                            if (digit_index >= eff_num)
                            begin
                                // Index past the digits in use wraps the counter.
                                digits_next = '{default: '0};
                                rolled_next = 1'b1;
                                start_sum   = 1'b1;
                            end
                            else if (action == ACT_INC)
                            begin
                                idx_next   = digit_index[IDX_W-1:0];
                                state_next = S_INC;
                            end
                            else if (action == ACT_WRITE)
                            begin
                                digits_next[digit_index[IDX_W-1:0]] =
                                    new_digit[DIGIT_WIDTH-1:0];
                                start_sum = 1'b1;
                            end
                            else
                            begin
                                idx_next   = digit_index[IDX_W-1:0];
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            start_sum = 1'b1;
                        end
                    endcase
                end
            end

            // One digit per divider pass, lowest first.
            S_DIV:
            begin
                if (div_done)
                begin
                    digits_next[idx_reg] = DIGIT_WIDTH'(div_remainder);
                    if (idx_reg == last_idx)
                    begin
                        start_sum = 1'b1;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        div_start = 1'b1;
                    end
                end
            end

            // Carry ripples upward one digit per cycle.
            S_INC:
            begin
                if (inc_digit >= eff_base)
                begin
                    digits_next[idx_reg] = '0;
                    if (idx_reg == last_idx)
                    begin
                        digits_next = '{default: '0};
                        rolled_next = 1'b1;
                        start_sum   = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    digits_next[idx_reg] = inc_digit[DIGIT_WIDTH-1:0];
                    start_sum            = 1'b1;
                end
            end

            S_READ:
            begin
                rd_next   = cur_digit;
                start_sum = 1'b1;
            end

            // Binary value by Horner's rule, top digit first.
            S_SUM:
            begin
                mac_ctl.step = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = S_MID;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end

            S_MID:
            begin
                sum_next      = mac_acc;
                mac_ctl.clear = 1'b1;
                idx_next      = last_idx;
                state_next    = S_MAX;
            end

            // Maximum value: every digit at base minus one.
            S_MAX:
            begin
                mac_ctl.step = 1'b1;
                mac_addend   = DIGIT_WIDTH'(eff_base - 1'b1);
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_rolled_next = rolled_reg;
                    out_bin_next    = sum_reg;
                    out_digit_next  = OUTDIG_W'(rd_reg);
                    out_max_next    = mac_acc;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Every request ends with the two evaluation passes.
        if (start_sum)
        begin
            idx_next      = last_idx;
            mac_ctl.clear = 1'b1;
            state_next    = S_SUM;
        end
    end

    // Control state and the digit row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            digits_reg    <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            digits_reg    <= digits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        rolled_reg     <= rolled_next;
        rd_reg         <= rd_next;
        sum_reg        <= sum_next;
        out_rolled_reg <= out_rolled_next;
        out_bin_reg    <= out_bin_next;
        out_digit_reg  <= out_digit_next;
        out_max_reg    <= out_max_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign rolled_over  = out_rolled_reg;
    assign binary_value = out_bin_reg;
    assign digit_value  = out_digit_reg;
    assign max_value    = out_max_reg;

endmodule

`default_nettype wire

/* sim/base_n_digit_counter_tb.sv */
// Testbench of the base-N digit counter: directed and random requests checked against a model.
module base_n_digit_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bndc_pkg::*;

    // Action codes with no function; the block must leave the digits alone.
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_SETTLE     = 600;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  val;
        logic [NEWDIG_W-1:0] digit;
    } odo_request_t;

    typedef struct packed {
        logic                rolled;
        logic [VALUE_W-1:0]  total;
        logic [OUTDIG_W-1:0] digit;
        logic [VALUE_W-1:0]  ceiling;
    } odo_result_t;

    // Clock, reset and block ports.
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = '0;
    logic [INDEX_W-1:0]  digit_index = '0;
    logic [VALUE_W-1:0]  value = '0;
    logic [NEWDIG_W-1:0] new_digit = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                rolled_over;
    logic [VALUE_W-1:0]  binary_value;
    logic [OUTDIG_W-1:0] digit_value;
    logic [VALUE_W-1:0]  max_value;

    // Model state: the digit row and the configuration registers.
    logic [DIGIT_WIDTH-1:0] odo_digits [MAX_DIGITS];
    logic [BASE_W-1:0]      model_base = BASE_RESET;
    logic [COUNT_W-1:0]     model_count = NUM_RESET;

    // Results still owed by the block, oldest first.
    odo_result_t pending_results [$];

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  next_gap = 0;
    bit  valid_driven = 1'b0;
    bit  drain_before_next = 1'b0;
    bit  no_idle = 1'b0;

    base_n_digit_counter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .digit_index  (digit_index),
        .value        (value),
        .new_digit    (new_digit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rolled_over  (rolled_over),
        .binary_value (binary_value),
        .digit_value  (digit_value),
        .max_value    (max_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (odo_digits[i]) odo_digits[i] = '0;
    end

    // Base actually used: the register clamped to 2 .. BASE_TOP.
    function automatic int unsigned radix_now();
        int unsigned b;
        b = model_base;
        if (b < 2) b = 2;
        if (b > BASE_TOP) b = BASE_TOP;
        return b;
    endfunction

    // Digit count actually used: the register clamped to 1 .. MAX_DIGITS.
    function automatic int unsigned width_now();
        int unsigned n;
        n = model_count;
        if (n < 1) n = 1;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        return n;
    endfunction

    // Largest value the counter holds, base^count - 1 modulo 2^64.
    function automatic logic [VALUE_W-1:0] odometer_ceiling();
        logic [VALUE_W-1:0] top;
        int unsigned        b;
        int unsigned        n;
        b = radix_now();
        n = width_now();
        top = 1;
        for (int i = 0; i < n; i++) top = top * b;
        return top - 1;
    endfunction

    function automatic void wipe_digits();
        foreach (odo_digits[i]) odo_digits[i] = '0;
    endfunction

    // Apply one request to the model digits and return the result it produces.
    function automatic odo_result_t advance_odometer(odo_request_t rq);
        odo_result_t        res;
        int unsigned        b;
        int unsigned        n;
        int unsigned        i;
        int unsigned        nxt;
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] mul;
        logic               carry;
        b = radix_now();
        n = width_now();
        res = '0;
        case (rq.act)
            ACT_CLEAR: wipe_digits();
            ACT_LOAD:
            begin
                wipe_digits();
                rest = rq.val;
                for (i = 0; i < n; i++)
                begin
                    odo_digits[i] = DIGIT_WIDTH'(rest % b);
                    rest = rest / b;
                end
            end
            ACT_INC, ACT_WRITE, ACT_READ:
            begin
                if (rq.idx >= n)
                begin
                    // An index past the digits in use clears the counter.
                    wipe_digits();
                    res.rolled = 1'b1;
                end
                else if (rq.act == ACT_INC)
                begin
                    // Ripple the carry upward; a digit at or above the base wraps to zero.
                    carry = 1'b1;
                    i = rq.idx;
                    while (carry && i < n)
                    begin
                        nxt = odo_digits[i] + 1;
                        if (nxt >= b)
                        begin
                            odo_digits[i] = '0;
                            i++;
                        end
                        else
                        begin
                            odo_digits[i] = DIGIT_WIDTH'(nxt);
                            carry = 1'b0;
                        end
                    end
                    if (carry)
                    begin
                        wipe_digits();
                        res.rolled = 1'b1;
                    end
                end
                else if (rq.act == ACT_WRITE)
                    odo_digits[rq.idx] = rq.digit[DIGIT_WIDTH-1:0];
                else
                    res.digit = OUTDIG_W'(odo_digits[rq.idx]);
            end
            default: ;
        endcase
        mul = 1;
        for (i = 0; i < n; i++)
        begin
            res.total = res.total + VALUE_W'(odo_digits[i]) * mul;
            mul = mul * b;
        end
        res.ceiling = odometer_ceiling();
        return res;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic odo_request_t odo_req(logic [ACTION_W-1:0] act, int unsigned idx,
                                             logic [VALUE_W-1:0] val, int unsigned dig);
        odo_request_t rq;
        rq.act = act;
        rq.idx = INDEX_W'(idx);
        rq.val = val;
        rq.digit = NEWDIG_W'(dig);
        return rq;
    endfunction

    // Random request shaped by the current configuration.
    function automatic odo_request_t random_request();
        odo_request_t rq;
        int unsigned  n;
        int unsigned  b;
        int           r;
        n = width_now();
        b = radix_now();
        r = $urandom_range(0, 99);
        if (r < 45) rq.act = ACT_INC;
        else if (r < 57) rq.act = ACT_LOAD;
        else if (r < 72) rq.act = ACT_WRITE;
        else if (r < 89) rq.act = ACT_READ;
        else if (r < 95) rq.act = ACT_CLEAR;
        else
        begin
            case ($urandom_range(0, 2))
                0: rq.act = ACT_SPARE_A;
                1: rq.act = ACT_SPARE_B;
                default: rq.act = ACT_SPARE_C;
            endcase
        end
        // Mostly in range; increments favor the lowest digit to climb toward roll-over.
        r = $urandom_range(0, 99);
        if (r < 12) rq.idx = INDEX_W'($urandom_range(0, 15));
        else if (rq.act == ACT_INC && r < 60) rq.idx = '0;
        else rq.idx = INDEX_W'($urandom_range(0, n - 1));
        r = $urandom_range(0, 99);
        if (r < 45) rq.val = odometer_ceiling() - VALUE_W'($urandom_range(0, 3));
        else if (r < 55) rq.val = odometer_ceiling() + VALUE_W'($urandom_range(1, 3));
        else if (r < 80) rq.val = {$urandom, $urandom};
        else rq.val = VALUE_W'($urandom_range(0, 1000));
        if ($urandom_range(0, 99) < 70) rq.digit = NEWDIG_W'($urandom_range(0, b - 1));
        else rq.digit = NEWDIG_W'($urandom_range(0, 255));
        return rq;
    endfunction

    // Lower the request valid once and put noise on the idle payload.
    task automatic drop_request_valid();
        if (valid_driven)
        begin
            in_valid <= 1'b0;
            action <= ACTION_W'($urandom);
            digit_index <= INDEX_W'($urandom);
            value <= {$urandom, $urandom};
            new_digit <= NEWDIG_W'($urandom);
            valid_driven = 1'b0;
        end
    endtask

    // Offer one request, wait for it to be taken, and record what it must produce.
    task automatic send_request(odo_request_t rq);
        if (drain_before_next)
        begin
            while (pending_results.size() != 0) @(posedge clk);
            drain_before_next = 1'b0;
        end
        repeat (next_gap) @(posedge clk);
        action <= rq.act;
        digit_index <= rq.idx;
        value <= rq.val;
        new_digit <= rq.digit;
        in_valid <= 1'b1;
        valid_driven = 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_results.push_back(advance_odometer(rq));
        next_gap = pick_gap();
        drain_before_next = ($urandom_range(0, 49) == 0);
        if (next_gap != 0 || drain_before_next) drop_request_valid();
    endtask

    // One APB write: setup cycle, then access until pready.
    task automatic write_register(logic reg_sel, logic [APB_DW-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({reg_sel, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_BASE) model_base = data[BASE_W-1:0];
        else model_count = data[COUNT_W-1:0];
    endtask

    // Registers change only with the block idle and every result delivered.
    task automatic set_config(int unsigned base_val, int unsigned count_val);
        drop_request_valid();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        write_register(REG_BASE, APB_DW'(base_val));
        write_register(REG_NUM, APB_DW'(count_val));
    endtask

    task automatic send_random_batch(int count);
        for (int k = 0; k < count; k++) send_request(random_request());
    endtask

    // Every action and the special cases at the reset configuration.
    task automatic test_reset_defaults();
        send_request(odo_req(ACT_READ, 0, '0, 0));
        send_request(odo_req(ACT_INC, 0, '0, 0));
        send_request(odo_req(ACT_LOAD, 0, 64'd12345678, 0));
        send_request(odo_req(ACT_INC, 2, '0, 0));
        send_request(odo_req(ACT_WRITE, 7, '0, 9));
        send_request(odo_req(ACT_READ, 7, '0, 0));
        send_request(odo_req(ACT_INC, 7, '0, 0));
        send_request(odo_req(ACT_LOAD, 0, '1, 0));
        send_request(odo_req(ACT_LOAD, 0, 64'd99999999, 0));
        send_request(odo_req(ACT_INC, 0, '0, 0));
        // A digit written at or above the base wraps on its next increment.
        send_request(odo_req(ACT_WRITE, 3, '0, 255));
        send_request(odo_req(ACT_READ, 3, '0, 0));
        send_request(odo_req(ACT_INC, 3, '0, 0));
        send_request(odo_req(ACT_READ, 4, '0, 0));
        // Indexes past the digits in use.
        send_request(odo_req(ACT_READ, 8, '0, 0));
        send_request(odo_req(ACT_INC, 15, '0, 0));
        send_request(odo_req(ACT_WRITE, 9, '0, 8'h5A));
        send_request(odo_req(ACT_LOAD, 0, 64'h8000_0000_0000_0001, 0));
        send_request(odo_req(ACT_CLEAR, 0, '1, 255));
        send_request(odo_req(ACT_SPARE_A, 0, '0, 0));
        send_request(odo_req(ACT_SPARE_B, 15, '1, 255));
        send_request(odo_req(ACT_SPARE_C, 5, 64'h5555_5555_5555_5555, 8'hAA));
        send_request(odo_req(ACT_WRITE, 0, '0, 0));
        send_request(odo_req(ACT_READ, 0, '0, 0));
    endtask

    // Register extremes, including values that get clamped.
    task automatic test_register_extremes();
        int unsigned ext_base [8] = '{0, 1, 2, 256, 257, 511, 3, 255};
        int unsigned ext_count [8] = '{0, 1, 15, 8, 9, 1, 8, 2};
        for (int k = 0; k < 8; k++)
        begin
            set_config(ext_base[k], ext_count[k]);
            send_random_batch(30);
        end
    endtask

    // Random configurations, with some phases at full rate on both sides.
    task automatic test_random_traffic();
        int unsigned bv;
        int unsigned nv;
        int          r;
        int unsigned ext_base [6] = '{0, 1, 2, 256, 257, 511};
        for (int phase = 0; phase < 17; phase++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30) bv = $urandom_range(2, 6);
            else if (r < 55) bv = $urandom_range(7, 16);
            else if (r < 75) bv = ext_base[$urandom_range(0, 5)];
            else bv = $urandom_range(0, 511);
            r = $urandom_range(0, 99);
            if (r < 30) nv = $urandom_range(1, 3);
            else if (r < 60) nv = $urandom_range(4, 8);
            else nv = $urandom_range(0, 15);
            set_config(bv, nv);
            no_idle = (phase % 5 == 4);
            send_random_batch(40);
            no_idle = 1'b0;
        end
    endtask

    // Binary counting with the sender waiting for the block to empty between bursts.
    task automatic test_drain_pause();
        set_config(2, 8);
        no_idle = 1'b1;
        send_random_batch(30);
        no_idle = 1'b0;
        for (int k = 0; k < 5; k++)
        begin
            send_random_batch(6);
            drop_request_valid();
            drain_before_next = 1'b1;
        end
    endtask

    task automatic flag_mismatch(string what, logic [VALUE_W-1:0] want,
                                 logic [VALUE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0h actual %0h", $time, what, want, got);
    endtask

    // Result checker, receiver stalls and the watchdog.
    always @(posedge clk)
    begin : result_monitor
        odo_result_t want;
        int          stall_left;
        idle_cycles++;
        if (in_valid === 1'b1 && in_stall === 1'b0) idle_cycles = 0;
        if (psel && penable && pwrite && pready === 1'b1) idle_cycles = 0;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            idle_cycles = 0;
            if (pending_results.size() == 0)
                flag_mismatch("result with nothing pending", '0, binary_value);
            else
            begin
                want = pending_results.pop_front();
                if (rolled_over !== want.rolled)
                    flag_mismatch("rolled_over", VALUE_W'(want.rolled), VALUE_W'(rolled_over));
                if (binary_value !== want.total)
                    flag_mismatch("binary_value", want.total, binary_value);
                if (digit_value !== want.digit)
                    flag_mismatch("digit_value", VALUE_W'(want.digit), VALUE_W'(digit_value));
                if (max_value !== want.ceiling)
                    flag_mismatch("max_value", want.ceiling, max_value);
            end
        end
        // Stall the result channel in random stretches.
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();
        test_drain_pause();
        drop_request_valid();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
